>>> rtl/npc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg
// Types, constants and the fixed palette for the nearest palette color search.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int TABLE_SIZE = 256;

	typedef logic [16:0] chan_t;
	typedef logic [33:0] sq_t;
	typedef logic [35:0] dist_t;
	typedef logic [7:0]  pidx_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} color_t;

	localparam dist_t START_BEST  = 36'h4_0000_0000;
	localparam pidx_t START_INDEX = 8'd7;

	localparam chan_t L000   = 17'd0;
	localparam chan_t L100   = 17'd65536;
	localparam chan_t L050   = 17'd32768;
	localparam chan_t L030   = 17'd19661;
	localparam chan_t L070   = 17'd45875;
	localparam chan_t L065   = 17'd42598;
	localparam chan_t L0325  = 17'd21299;
	localparam chan_t L025   = 17'd16384;
	localparam chan_t L015   = 17'd9830;
	localparam chan_t L0075  = 17'd4915;
	localparam chan_t L0625  = 17'd40960;
	localparam chan_t L01625 = 17'd10650;
	localparam chan_t L04063 = 17'd26627;
	localparam chan_t L0125  = 17'd8192;
	localparam chan_t L03125 = 17'd20480;
	localparam chan_t L01875 = 17'd12288;
	localparam chan_t L00375 = 17'd2458;
	localparam chan_t L00938 = 17'd6147;
	localparam chan_t L075   = 17'd49152;
	localparam chan_t L04875 = 17'd31949;
	localparam chan_t L0375  = 17'd24576;
	localparam chan_t L0225  = 17'd14746;
	localparam chan_t L01125 = 17'd7373;
	localparam chan_t L0875  = 17'd57344;
	localparam chan_t L05688 = 17'd37277;
	localparam chan_t L04375 = 17'd28672;
	localparam chan_t L02625 = 17'd17203;
	localparam chan_t L01313 = 17'd8605;
	localparam chan_t L033   = 17'd21627;
	localparam chan_t L0464  = 17'd30409;
	localparam chan_t L0598  = 17'd39191;
	localparam chan_t L0732  = 17'd47972;
	localparam chan_t L0866  = 17'd56754;

	localparam color_t PALETTE [TABLE_SIZE] = '{
		'{L100,L100,L100}, '{L100,L000,L000}, '{L100,L100,L000}, '{L000,L100,L000},
		'{L000,L100,L100}, '{L000,L000,L100}, '{L100,L000,L100}, '{L100,L100,L100},
		'{L030,L030,L030}, '{L070,L070,L070},
		'{L100,L000,L000}, '{L100,L050,L050}, '{L065,L000,L000}, '{L065,L0325,L0325},
		'{L050,L000,L000}, '{L050,L025,L025}, '{L030,L000,L000}, '{L030,L015,L015},
		'{L015,L000,L000}, '{L015,L0075,L0075},
		'{L100,L025,L000}, '{L100,L0625,L050}, '{L065,L01625,L000}, '{L065,L04063,L0325},
		'{L050,L0125,L000}, '{L050,L03125,L025}, '{L030,L0075,L000}, '{L030,L01875,L015},
		'{L015,L00375,L000}, '{L015,L00938,L0075},
		'{L100,L050,L000}, '{L100,L075,L050}, '{L065,L0325,L000}, '{L065,L04875,L0325},
		'{L050,L025,L000}, '{L050,L0375,L025}, '{L030,L015,L000}, '{L030,L0225,L015},
		'{L015,L0075,L000}, '{L015,L01125,L0075},
		'{L100,L075,L000}, '{L100,L0875,L050}, '{L065,L04875,L000}, '{L065,L05688,L0325},
		'{L050,L0375,L000}, '{L050,L04375,L025}, '{L030,L0225,L000}, '{L030,L02625,L015},
		'{L015,L01125,L000}, '{L015,L01313,L0075},
		'{L100,L100,L000}, '{L100,L100,L050}, '{L065,L065,L000}, '{L065,L065,L0325},
		'{L050,L050,L000}, '{L050,L050,L025}, '{L030,L030,L000}, '{L030,L030,L015},
		'{L015,L015,L000}, '{L015,L015,L0075},
		'{L075,L100,L000}, '{L0875,L100,L050}, '{L04875,L065,L000}, '{L05688,L065,L0325},
		'{L0375,L050,L000}, '{L04375,L050,L025}, '{L0225,L030,L000}, '{L02625,L030,L015},
		'{L01125,L015,L000}, '{L01313,L015,L0075},
		'{L050,L100,L000}, '{L075,L100,L050}, '{L0325,L065,L000}, '{L04875,L065,L0325},
		'{L025,L050,L000}, '{L0375,L050,L025}, '{L015,L030,L000}, '{L0225,L030,L015},
		'{L0075,L015,L000}, '{L01125,L015,L0075},
		'{L025,L100,L000}, '{L0625,L100,L050}, '{L01625,L065,L000}, '{L04063,L065,L0325},
		'{L0125,L050,L000}, '{L03125,L050,L025}, '{L0075,L030,L000}, '{L01875,L030,L015},
		'{L00375,L015,L000}, '{L00938,L015,L0075},
		'{L000,L100,L000}, '{L050,L100,L050}, '{L000,L065,L000}, '{L0325,L065,L0325},
		'{L000,L050,L000}, '{L025,L050,L025}, '{L000,L030,L000}, '{L015,L030,L015},
		'{L000,L015,L000}, '{L0075,L015,L0075},
		'{L000,L100,L025}, '{L050,L100,L0625}, '{L000,L065,L01625}, '{L0325,L065,L04063},
		'{L000,L050,L0125}, '{L025,L050,L03125}, '{L000,L030,L0075}, '{L015,L030,L01875},
		'{L000,L015,L00375}, '{L0075,L015,L00938},
		'{L000,L100,L050}, '{L050,L100,L075}, '{L000,L065,L0325}, '{L0325,L065,L04875},
		'{L000,L050,L025}, '{L025,L050,L0375}, '{L000,L030,L015}, '{L015,L030,L0225},
		'{L000,L015,L0075}, '{L0075,L015,L01125},
		'{L000,L100,L075}, '{L050,L100,L0875}, '{L000,L065,L04875}, '{L0325,L065,L05688},
		'{L000,L050,L0375}, '{L025,L050,L04375}, '{L000,L030,L0225}, '{L015,L030,L02625},
		'{L000,L015,L01125}, '{L0075,L015,L01313},
		'{L000,L100,L100}, '{L050,L100,L100}, '{L000,L065,L065}, '{L0325,L065,L065},
		'{L000,L050,L050}, '{L025,L050,L050}, '{L000,L030,L030}, '{L015,L030,L030},
		'{L000,L015,L015}, '{L0075,L015,L015},
		'{L000,L075,L100}, '{L050,L0875,L100}, '{L000,L04875,L065}, '{L0325,L05688,L065},
		'{L000,L0375,L050}, '{L025,L04375,L050}, '{L000,L0225,L030}, '{L015,L02625,L030},
		'{L000,L01125,L015}, '{L0075,L01313,L015},
		'{L000,L050,L100}, '{L050,L075,L100}, '{L000,L0325,L065}, '{L0325,L04875,L065},
		'{L000,L025,L050}, '{L025,L0375,L050}, '{L000,L015,L030}, '{L015,L0225,L030},
		'{L000,L0075,L015}, '{L0075,L01125,L015},
		'{L000,L025,L100}, '{L050,L0625,L100}, '{L000,L01625,L065}, '{L0325,L04063,L065},
		'{L000,L0125,L050}, '{L025,L03125,L050}, '{L000,L0075,L030}, '{L015,L01875,L030},
		'{L000,L00375,L015}, '{L0075,L00938,L015},
		'{L000,L000,L100}, '{L050,L050,L100}, '{L000,L000,L065}, '{L0325,L0325,L065},
		'{L000,L000,L050}, '{L025,L025,L050}, '{L000,L000,L030}, '{L015,L015,L030},
		'{L000,L000,L015}, '{L0075,L0075,L015},
		'{L025,L000,L100}, '{L0625,L050,L100}, '{L01625,L000,L065}, '{L04063,L0325,L065},
		'{L0125,L000,L050}, '{L03125,L025,L050}, '{L0075,L000,L030}, '{L01875,L015,L030},
		'{L00375,L000,L015}, '{L00938,L0075,L015},
		'{L050,L000,L100}, '{L075,L050,L100}, '{L0325,L000,L065}, '{L04875,L0325,L065},
		'{L025,L000,L050}, '{L0375,L025,L050}, '{L015,L000,L030}, '{L0225,L015,L030},
		'{L0075,L000,L015}, '{L01125,L0075,L015},
		'{L075,L000,L100}, '{L0875,L050,L100}, '{L04875,L000,L065}, '{L05688,L0325,L065},
		'{L0375,L000,L050}, '{L04375,L025,L050}, '{L0225,L000,L030}, '{L02625,L015,L030},
		'{L01125,L000,L015}, '{L01313,L0075,L015},
		'{L100,L000,L100}, '{L100,L050,L100}, '{L065,L000,L065}, '{L065,L0325,L065},
		'{L050,L000,L050}, '{L050,L025,L050}, '{L030,L000,L030}, '{L030,L015,L030},
		'{L015,L000,L015}, '{L015,L0075,L015},
		'{L100,L000,L075}, '{L100,L050,L0875}, '{L065,L000,L04875}, '{L065,L0325,L05688},
		'{L050,L000,L0375}, '{L050,L025,L04375}, '{L030,L000,L0225}, '{L030,L015,L02625},
		'{L015,L000,L01125}, '{L015,L0075,L01313},
		'{L100,L000,L050}, '{L100,L050,L075}, '{L065,L000,L0325}, '{L065,L0325,L04875},
		'{L050,L000,L025}, '{L050,L025,L0375}, '{L030,L000,L015}, '{L030,L015,L0225},
		'{L015,L000,L0075}, '{L015,L0075,L01125},
		'{L100,L000,L025}, '{L100,L050,L0625}, '{L065,L000,L01625}, '{L065,L0325,L04063},
		'{L050,L000,L0125}, '{L050,L025,L03125}, '{L030,L000,L0075}, '{L030,L015,L01875},
		'{L015,L000,L00375}, '{L015,L0075,L00938},
		'{L033,L033,L033}, '{L0464,L0464,L0464}, '{L0598,L0598,L0598}, '{L0732,L0732,L0732},
		'{L0866,L0866,L0866}, '{L100,L100,L100}
	};

endpackage
`default_nettype wire

>>> rtl/npc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npc_front
// Two-word input queue; holds colors while the search engine is busy.
// ----------------------------------------------------------------------------
module npc_front import npc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	output logic        full,
	input  wire color_t color_in,
	output logic        avail,
	input  wire logic   take,
	output color_t      color_out
);

	color_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_take;

	assign full      = (cnt_q == 2'd2);
	assign avail     = (cnt_q != 2'd0);
	assign do_push   = push && !full;
	assign do_take   = take && avail;
	assign color_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_take)
				rd_q <= !rd_q;
			if (do_push && !do_take)
				cnt_q <= cnt_q + 2'd1;
			else if (do_take && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= color_in;
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with count");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !take) |=> full) else $error("full queue lost a word");
`endif

endmodule
`default_nettype wire

>>> rtl/npc_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npc_search
// Scan engine: one palette entry per cycle through diff, square, sum and
// compare stages, with a result register toward the output side.
// ----------------------------------------------------------------------------
module npc_search import npc_pkg::*; #(
	parameter int PALETTE_ENTRIES = 255
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   avail,
	output logic        take,
	input  wire color_t color_in,
	output logic        empty,
	input  wire logic   pop,
	output pidx_t       color_index
);

	localparam pidx_t LAST = 8'(PALETTE_ENTRIES - 1);

	logic   busy_q;
	pidx_t  idx_q;
	color_t color_q;

	logic   v_s1, v_s2, v_s3;
	logic   first_s1, first_s2, first_s3;
	logic   last_s1, last_s2, last_s3;
	pidx_t  idx_s1, idx_s2, idx_s3;
	chan_t  dr_s1, dg_s1, db_s1;
	sq_t    sr_s2, sg_s2, sb_s2;
	dist_t  sum_s3;

	dist_t  best_q;
	pidx_t  best_idx_q;
	logic   out_valid_q;
	pidx_t  color_index_q;

	color_t entry;
	dist_t  cur_best;
	pidx_t  cur_idx;
	logic   closer;
	logic   idle;
	logic   done;

	assign idle  = !busy_q && !v_s1 && !v_s2 && !v_s3;
	assign take  = avail && idle && !out_valid_q;
	assign done  = v_s3 && last_s3;
	assign entry = PALETTE[idx_q];

	assign cur_best = first_s3 ? START_BEST : best_q;
	assign cur_idx  = first_s3 ? START_INDEX : best_idx_q;
	assign closer   = (sum_s3 < cur_best);

	assign empty       = !out_valid_q;
	assign color_index = color_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == LAST)
					busy_q <= 1'b0;
				idx_q <= idx_q + 8'd1;
			end
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (done)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			color_q <= color_in;
		// s1: channel distances
		dr_s1    <= (color_q.r > entry.r) ? color_q.r - entry.r : entry.r - color_q.r;
		dg_s1    <= (color_q.g > entry.g) ? color_q.g - entry.g : entry.g - color_q.g;
		db_s1    <= (color_q.b > entry.b) ? color_q.b - entry.b : entry.b - color_q.b;
		idx_s1   <= idx_q;
		first_s1 <= (idx_q == 8'd0);
		last_s1  <= (idx_q == LAST);
		// s2: squares
		sr_s2    <= 34'(dr_s1) * 34'(dr_s1);
		sg_s2    <= 34'(dg_s1) * 34'(dg_s1);
		sb_s2    <= 34'(db_s1) * 34'(db_s1);
		idx_s2   <= idx_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		// s3: sum
		sum_s3   <= 36'(sr_s2) + 36'(sg_s2) + 36'(sb_s2);
		idx_s3   <= idx_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		// compare
		if (v_s3) begin
			best_q     <= closer ? sum_s3 : cur_best;
			best_idx_q <= closer ? idx_s3 : cur_idx;
		end
		if (done)
			color_index_q <= closer ? idx_s3 : cur_idx;
	end

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (!busy_q && !out_valid_q)) else $error("scan started while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q) else $error("result register overwritten");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && idx_q == LAST) |=> !busy_q) else $error("scan ran past last entry");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (color_index_q <= LAST)) else $error("index beyond palette");
`endif

endmodule
`default_nettype wire

>>> rtl/nearest_palette_color.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color
// Nearest-color search over a fixed palette, queue interface on both sides.
// ----------------------------------------------------------------------------
// Each word is an RGB color in unsigned 1.16 fixed point; the result is the
// index of the palette entry at the smallest squared distance, earliest index
// on ties. A single distance unit scans one palette entry per cycle behind a
// three-stage diff, square and sum pipeline, and the result is registered
// when the last entry has been compared. A two-word input queue keeps taking
// colors during a scan; the next scan starts once the pipeline has drained
// and the previous result has been popped.
module nearest_palette_color import npc_pkg::*; #(
	parameter int PALETTE_ENTRIES = 255
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [16:0]  red,
	input  wire logic [16:0]  green,
	input  wire logic [16:0]  blue,
	output logic              empty,
	input  wire logic         pop,
	output logic [7:0]        color_index
);

	color_t color_in;
	color_t color_q;
	logic   avail;
	logic   take;

	assign color_in = '{r: red, g: green, b: blue};

	npc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.color_in  (color_in),
		.avail     (avail),
		.take      (take),
		.color_out (color_q)
	);

	npc_search #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.take        (take),
		.color_in    (color_q),
		.empty       (empty),
		.pop         (pop),
		.color_index (color_index)
	);

endmodule
`default_nettype wire

>>> sim/nearest_palette_color_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_tb
// Self-checking testbench for the nearest palette color search.
// ----------------------------------------------------------------------------
// Colors are pushed through the input queue and indices popped from the result
// queue, both sides with random gaps. A scoreboard holds its own copy of the
// palette, scans it for every accepted color and compares each popped index
// with the oldest prediction. Stimulus covers exact palette hits, duplicate
// entries, equidistant points, channels above 1.0 and near-miss colors.
// ----------------------------------------------------------------------------
module nearest_palette_color_tb;
	import npc_pkg::*;

	localparam int SCAN_LEN      = 255;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int QUIET_LIMIT   = 5000;
	localparam int TAIL_CYCLES   = 300;
	localparam int CHAN_MAX      = 131071;

	localparam longint unsigned SCAN_START_DIST  = 64'h4_0000_0000;
	localparam pidx_t           SCAN_START_INDEX = 8'd7;

	// shade level x eighths of full scale; eighths 1 and 3 never occur
	localparam int SHADE [5][9] = '{
		'{0, 0, 16384, 0, 32768, 40960, 49152, 57344, 65536},
		'{0, 0, 10650, 0, 21299, 26627, 31949, 37277, 42598},
		'{0, 0,  8192, 0, 16384, 20480, 24576, 28672, 32768},
		'{0, 0,  4915, 0,  9830, 12288, 14746, 17203, 19661},
		'{0, 0,  2458, 0,  4915,  6147,  7373,  8605,  9830}
	};

	// hue ring in quarter steps, one per group of ten shades
	localparam int HUE [24][3] = '{
		'{4,0,0}, '{4,1,0}, '{4,2,0}, '{4,3,0}, '{4,4,0}, '{3,4,0}, '{2,4,0}, '{1,4,0},
		'{0,4,0}, '{0,4,1}, '{0,4,2}, '{0,4,3}, '{0,4,4}, '{0,3,4}, '{0,2,4}, '{0,1,4},
		'{0,0,4}, '{1,0,4}, '{2,0,4}, '{3,0,4}, '{4,0,4}, '{4,0,3}, '{4,0,2}, '{4,0,1}
	};

	// entries 0-9 then 250-255
	localparam int FIXED_ENTRIES [16][3] = '{
		'{65536,65536,65536}, '{65536,0,0}, '{65536,65536,0}, '{0,65536,0},
		'{0,65536,65536}, '{0,0,65536}, '{65536,0,65536}, '{65536,65536,65536},
		'{19661,19661,19661}, '{45875,45875,45875},
		'{21627,21627,21627}, '{30409,30409,30409}, '{39191,39191,39191},
		'{47972,47972,47972}, '{56754,56754,56754}, '{65536,65536,65536}
	};

	localparam int DIRECTED_N = 22;
	localparam int DIRECTED [DIRECTED_N][3] = '{
		'{0,0,0}, '{131071,131071,131071}, '{65536,65536,65536}, '{65536,0,0},
		'{65536,65536,0}, '{0,65536,0}, '{0,65536,65536}, '{0,0,65536},
		'{65536,0,65536}, '{19661,19661,19661}, '{45875,45875,45875},
		'{52363,52363,52363}, '{131071,0,0}, '{0,131071,0}, '{0,0,131071},
		'{21627,21627,21627}, '{65535,65535,65535}, '{1,1,1},
		'{131071,131071,0}, '{42598,21299,21299}, '{65536,16384,0}, '{9830,4915,7373}
	};

	class palette_scoreboard;
		color_t entries [256];
		pidx_t  nearest_q [$];
		bit     index_seen [256];
		int     mismatches;
		int     colors_noted;
		int     indices_checked;

		function new();
			int n, lvl, e;
			int ch_val [3];
			for (int i = 0; i < 10; i++)
				entries[i] = {chan_t'(FIXED_ENTRIES[i][0]), chan_t'(FIXED_ENTRIES[i][1]),
					chan_t'(FIXED_ENTRIES[i][2])};
			for (int i = 0; i < 6; i++)
				entries[250 + i] = {chan_t'(FIXED_ENTRIES[10 + i][0]),
					chan_t'(FIXED_ENTRIES[10 + i][1]), chan_t'(FIXED_ENTRIES[10 + i][2])};
			for (int k = 0; k < 24; k++) begin
				for (int j = 0; j < 10; j++) begin
					n = 10 + 10 * k + j;
					lvl = j / 2;
					for (int ch = 0; ch < 3; ch++) begin
						// odd shades are the hue mixed half way to white
						e = (j % 2) ? HUE[k][ch] + 4 : 2 * HUE[k][ch];
						ch_val[ch] = SHADE[lvl][e];
					end
					entries[n] = {chan_t'(ch_val[0]), chan_t'(ch_val[1]), chan_t'(ch_val[2])};
				end
			end
			mismatches = 0;
			colors_noted = 0;
			indices_checked = 0;
		endfunction

		function longint unsigned sq_gap(chan_t a, chan_t b);
			longint unsigned d;
			d = (a > b) ? a - b : b - a;
			return d * d;
		endfunction

		function pidx_t nearest(color_t c);
			longint unsigned best, d;
			pidx_t best_i;
			best = SCAN_START_DIST;
			best_i = SCAN_START_INDEX;
			for (int i = 0; i < SCAN_LEN; i++) begin
				d = sq_gap(c.r, entries[i].r) + sq_gap(c.g, entries[i].g)
					+ sq_gap(c.b, entries[i].b);
				if (d < best) begin
					best = d;
					best_i = pidx_t'(i);
				end
			end
			return best_i;
		endfunction

		function void note_color(color_t c);
			nearest_q = {nearest_q, nearest(c)};
			colors_noted++;
		endfunction

		function void check_index(pidx_t got);
			pidx_t want;
			indices_checked++;
			if (nearest_q.size() == 0) begin
				$error("color_index: unexpected word, expected none, actual %0d", got);
				mismatches++;
			end else begin
				want = nearest_q.pop_front();
				index_seen[want] = 1'b1;
				if (got !== want) begin
					$error("color_index: expected %0d, actual %0d", want, got);
					mismatches++;
				end
			end
		endfunction

		function int pending();
			return nearest_q.size();
		endfunction

		function int distinct_indices();
			int cnt;
			cnt = 0;
			foreach (index_seen[i])
				if (index_seen[i])
					cnt++;
			return cnt;
		endfunction
	endclass

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic [16:0] red    = '0;
	logic [16:0] green  = '0;
	logic [16:0] blue   = '0;
	logic        pop    = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  color_index;

	logic calm = 1'b0;
	int   quiet_cycles = 0;

	palette_scoreboard sb = new();

	nearest_palette_color #(.PALETTE_ENTRIES(SCAN_LEN)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.empty       (empty),
		.pop         (pop),
		.color_index (color_index)
	);

	always #2 clk = ~clk;

	// result side: random stalls unless in the calm stretch
	always @(posedge clk) begin
		if (arst_n)
			pop <= calm || ($urandom_range(99) >= 8);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_color({red, green, blue});
			if (pop && !empty)
				sb.check_index(color_index);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_color(input color_t c);
		push  <= 1'b1;
		red   <= c.r;
		green <= c.g;
		blue  <= c.b;
		do @(posedge clk); while (full);
	endtask

	initial begin
		color_t c;
		int gap, mode, pick, v;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_N; i++)
			send_color({chan_t'(DIRECTED[i][0]), chan_t'(DIRECTED[i][1]),
				chan_t'(DIRECTED[i][2])});

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= (n >= 400 && n < 650);
			gap = 0;
			if (!(n >= 400 && n < 650)) begin
				while ($urandom_range(99) < 8)
					gap++;
				// occasional long gap lets the scan drain so words land on any phase
				if ($urandom_range(99) < 3)
					gap += $urandom_range(600, 1);
			end
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			mode = $urandom_range(99);
			pick = $urandom_range(255);
			for (int ch = 0; ch < 3; ch++) begin
				if (mode < 70)
					v = $urandom_range(65536);
				else if (mode < 80)
					v = $urandom_range(CHAN_MAX);
				else begin
					v = int'(sb.entries[pick][ch * 17 +: 17]) + $urandom_range(128) - 64;
					if (v < 0)
						v = 0;
				end
				c[ch * 17 +: 17] = chan_t'(v);
			end
			send_color(c);
		end
		push <= 1'b0;

		while (sb.pending() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d colors (%0d directed), checked %0d indices", sb.colors_noted,
			DIRECTED_N, sb.indices_checked);
		$display("%0d distinct palette indices returned, %0d mismatches",
			sb.distinct_indices(), sb.mismatches);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/npc_pkg.sv
rtl/npc_front.sv
rtl/npc_search.sv
rtl/nearest_palette_color.sv
sim/nearest_palette_color_tb.sv
